>>> hdl/tsrg_pkg.sv
// Shared types and constants for the tensor shard range generator.
// Used by the front, queue, back, top level and checker; depends on nothing.
package tsrg_pkg;

  localparam int unsigned MaxDevices   = 16;
  localparam int unsigned MaxDims      = 4;
  localparam int unsigned NumDimFields = 4;
  localparam int unsigned QueueDepth   = 2;

  localparam int unsigned InDataW  = 264;
  localparam int unsigned InUserW  = 2;
  localparam int unsigned OutDataW = 136;
  localparam int unsigned OutUserW = 10;

  // Largest dimension count that is honored.
  localparam logic [2:0] NdLimit =
      3'((MaxDims < NumDimFields) ? MaxDims : NumDimFields);

  // Sharding kinds.
  localparam logic [1:0] KindReplicate   = 2'd0;
  localparam logic [1:0] KindRowwise     = 2'd1;
  localparam logic [1:0] KindColwise     = 2'd2;
  localparam logic [1:0] KindUnsupported = 2'd3;

  // Result status codes.
  localparam logic [1:0] StatusOk          = 2'd0;
  localparam logic [1:0] StatusInvalid     = 2'd1;
  localparam logic [1:0] StatusUnsupported = 2'd2;

  // Configuration register indexes.
  localparam logic CfgWorldSize  = 1'b0;
  localparam logic CfgDeviceKind = 1'b1;

  typedef struct packed {
    logic [4:0]        elem_bytes;
    logic [3:0][31:0]  dims;
    logic [2:0]        num_dims;
    logic [63:0]       end_addr;
    logic [63:0]       start_addr;
  } desc_t;

  // One queued descriptor, ready for the output side to expand.
  typedef struct packed {
    logic        split;
    logic [1:0]  status;
    logic [4:0]  count;
    logic [4:0]  rem;
    logic [63:0] saddr;
    logic [63:0] eaddr;
    logic [63:0] chunk_bytes;
    logic [63:0] chunk_bytes_plus;
  } shard_entry_t;

endpackage

>>> hdl/tensor_shard_range_generator_unit.sv
// Top level of the tensor shard range generator: configuration registers,
// stream ports and the front / queue / back chain. Depends on tsrg_pkg.
//
// Usage: a tensor descriptor enters on the s_axis channel; for it the block
// sends one shard word per device on the m_axis channel, ordinals 0 upward,
// with tlast on the final one. A rowwise or colwise split with one device, or
// an unsupported kind, gives a single word with a nonzero status instead.
// The user must write the device count and device kind through the cfg port
// only while idle; the block does not enforce this. A replicate or error
// descriptor goes to the push step on acceptance; a split descriptor holds the
// front while five 64x32 products are formed on one 32x32 multiplier, each as
// a low half then a high half, with the division by world size running
// alongside. The back emits one word per cycle while the receiver does not
// stall. A two-entry queue lets the front take the next word while the back is
// still emitting. When the receiver stalls, the output register holds its word
// and the queue fills before s_axis_tready drops.
// Reset clears all control state and sets the device count to 1, the kind to 0.
module tensor_shard_range_generator_unit import tsrg_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  // start_addr[63:0], end_addr[127:64], num_dims[130:128], dim_0[162:131],
  // dim_1[194:163], dim_2[226:195], dim_3[258:227], elem_bytes[263:259]
  input  logic [InDataW-1:0]  s_axis_tdata,
  // kind[1:0]
  input  logic [InUserW-1:0]  s_axis_tuser,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // device_ordinal[3:0], shard_start[67:4], shard_end[131:68], zero fill
  output logic [OutDataW-1:0] m_axis_tdata,
  // out_kind[7:0], status[9:8]
  output logic [OutUserW-1:0] m_axis_tuser,
  output logic                m_axis_tlast,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  input  logic                cfg_we_i,
  input  logic                cfg_idx_i,
  input  logic [7:0]          cfg_data_i
);

  logic [4:0] dev_count_q;
  logic [7:0] device_kind_q;
  logic [4:0] ws_eff;

  desc_t        desc;
  logic         push_valid, push_ready, head_valid, pop;
  shard_entry_t push_entry, head;

  logic [3:0]  out_ordinal;
  logic [7:0]  out_kind;
  logic [63:0] out_lo, out_end;
  logic [1:0]  out_status;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dev_count_q   <= 5'd1;
      device_kind_q <= 8'd0;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CfgWorldSize:  dev_count_q   <= cfg_data_i[4:0];
        CfgDeviceKind: device_kind_q <= cfg_data_i;
      endcase
    end
  end

  // Zero devices counts as one; larger values saturate.
  always_comb begin
    if (dev_count_q == 5'd0) begin
      ws_eff = 5'd1;
    end else if (dev_count_q > 5'(MaxDevices)) begin
      ws_eff = 5'(MaxDevices);
    end else begin
      ws_eff = dev_count_q;
    end
  end

  assign desc = desc_t'(s_axis_tdata);

  tsrg_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .in_kind_i    (s_axis_tuser),
    .in_desc_i    (desc),
    .ws_i         (ws_eff),
    .push_valid_o (push_valid),
    .push_ready_i (push_ready),
    .push_entry_o (push_entry)
  );

  tsrg_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_entry_i (push_entry),
    .head_valid_o (head_valid),
    .pop_i        (pop),
    .head_o       (head)
  );

  tsrg_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .head_valid_i  (head_valid),
    .head_i        (head),
    .pop_o         (pop),
    .device_kind_i (device_kind_q),
    .out_valid_o   (m_axis_tvalid),
    .out_ready_i   (m_axis_tready),
    .out_ordinal_o (out_ordinal),
    .out_kind_o    (out_kind),
    .out_lo_o      (out_lo),
    .out_end_o     (out_end),
    .out_status_o  (out_status),
    .out_last_o    (m_axis_tlast)
  );

  assign m_axis_tdata = {4'd0, out_end, out_lo, out_ordinal};
  assign m_axis_tuser = {out_status, out_kind};

endmodule

>>> hdl/tsrg_front.sv
// Front part: accepts descriptors, classifies them and computes stride,
// chunk and remainder with one shared 32x32 multiplier and a radix-16 divider.
// Depends on tsrg_pkg.
module tsrg_front import tsrg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         in_valid_i,
  output logic         in_ready_o,
  input  logic [1:0]   in_kind_i,
  input  desc_t        in_desc_i,
  input  logic [4:0]   ws_i,
  output logic         push_valid_o,
  input  logic         push_ready_i,
  output shard_entry_t push_entry_o
);

  localparam logic [3:0] PushStep = 4'd10;
  localparam logic [3:0] DivSteps = 4'd8;

  logic        busy_q, busy_d;
  logic [3:0]  step_q, step_d;
  logic        accept;

  logic [2:0][31:0] fac_q;
  logic [4:0]  elem_q;
  logic [63:0] acc_q, tmp_q, stride_q;
  logic [31:0] quo_q;
  logic [4:0]  rmd_q;
  logic [4:0]  ws_q;
  logic        split_q;
  logic [1:0]  status_q;
  logic [4:0]  cnt_q;
  logic [63:0] saddr_q, eaddr_q;

  logic [2:0]       nd_sat;
  logic [2:0][31:0] fac_in;
  logic [31:0]      split_in;
  logic             is_row, spec_inv, spec_uns, split_in_kind;

  logic [31:0] mul_a, mul_b;
  logic [63:0] prod;
  logic [31:0] quo_d;
  logic [4:0]  rmd_d;
  logic        working;

  assign accept       = in_valid_i && in_ready_o;
  assign in_ready_o   = !busy_q || (step_q == PushStep && push_ready_i);
  assign push_valid_o = busy_q && (step_q == PushStep);
  assign working      = busy_q && split_q && (step_q < PushStep);

  // Classification and the factor list for the stride product.
  always_comb begin
    nd_sat   = (in_desc_i.num_dims > NdLimit) ? NdLimit : in_desc_i.num_dims;
    is_row   = (in_kind_i == KindRowwise);
    spec_inv = (ws_i == 5'd1) && (in_kind_i != KindReplicate);
    spec_uns = !spec_inv && (in_kind_i == KindUnsupported);
    split_in_kind = !spec_inv && (in_kind_i == KindRowwise || in_kind_i == KindColwise);
    for (int j = 0; j < 3; j++) begin
      if (3'(j + 1) < nd_sat) begin
        fac_in[j] = is_row ? in_desc_i.dims[j + 1] : in_desc_i.dims[j];
      end else begin
        fac_in[j] = 32'd1;
      end
    end
    if (is_row || nd_sat == 3'd0) begin
      split_in = in_desc_i.dims[0];
    end else begin
      split_in = in_desc_i.dims[2'(nd_sat - 3'd1)];
    end
  end

  // Each 64x32 product is formed low half first, then high half.
  always_comb begin
    mul_a = step_q[0] ? acc_q[63:32] : acc_q[31:0];
    unique case (step_q[3:1])
      3'd0:    mul_b = fac_q[0];
      3'd1:    mul_b = fac_q[1];
      3'd2:    mul_b = fac_q[2];
      3'd3:    mul_b = {27'd0, elem_q};
      3'd4:    mul_b = quo_q;
      default: mul_b = 32'd0;
    endcase
    prod = mul_a * mul_b;
  end

  // Four quotient bits per cycle of a restoring division by world size.
  always_comb begin
    logic [4:0]  r;
    logic [4:0]  sh;
    logic [31:0] q;
    r = rmd_q;
    q = quo_q;
    for (int k = 0; k < 4; k++) begin
      sh = {r[3:0], q[31]};
      q  = {q[30:0], 1'b0};
      if (sh >= ws_q) begin
        r    = sh - ws_q;
        q[0] = 1'b1;
      end else begin
        r = sh;
      end
    end
    quo_d = q;
    rmd_d = r;
  end

  always_comb begin
    busy_d = busy_q;
    step_d = step_q;
    priority if (accept) begin
      busy_d = 1'b1;
      step_d = split_in_kind ? 4'd0 : PushStep;
    end else if (working) begin
      step_d = step_q + 4'd1;
    end else if (push_valid_o && push_ready_i) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      step_q <= 4'd0;
    end else begin
      busy_q <= busy_d;
      step_q <= step_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      acc_q    <= 64'd1;
      fac_q    <= fac_in;
      elem_q   <= in_desc_i.elem_bytes;
      quo_q    <= split_in;
      rmd_q    <= 5'd0;
      ws_q     <= ws_i;
      split_q  <= split_in_kind;
      status_q <= spec_inv ? StatusInvalid : (spec_uns ? StatusUnsupported : StatusOk);
      cnt_q    <= (spec_inv || spec_uns) ? 5'd1 : ws_i;
      saddr_q  <= (spec_inv || spec_uns) ? 64'd0 : in_desc_i.start_addr;
      eaddr_q  <= (spec_inv || spec_uns) ? 64'd0 : in_desc_i.end_addr;
    end else if (working) begin
      if (!step_q[0]) begin
        tmp_q <= prod;
      end else begin
        acc_q <= tmp_q + {prod[31:0], 32'd0};
      end
      // The accumulator holds the full stride once the element size is in.
      if (step_q == DivSteps) begin
        stride_q <= acc_q;
      end
      if (step_q < DivSteps) begin
        quo_q <= quo_d;
        rmd_q <= rmd_d;
      end
    end
  end

  always_comb begin
    push_entry_o.split            = split_q;
    push_entry_o.status           = status_q;
    push_entry_o.count            = cnt_q;
    push_entry_o.rem              = rmd_q;
    push_entry_o.saddr            = saddr_q;
    push_entry_o.eaddr            = eaddr_q;
    push_entry_o.chunk_bytes      = acc_q;
    push_entry_o.chunk_bytes_plus = acc_q + stride_q;
  end

endmodule

>>> hdl/tsrg_queue.sv
// Short queue between the front and back parts of the shard generator.
// Holds prepared descriptors; depends on tsrg_pkg.
module tsrg_queue import tsrg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_valid_i,
  output logic         push_ready_o,
  input  shard_entry_t push_entry_i,
  output logic         head_valid_o,
  input  logic         pop_i,
  output shard_entry_t head_o
);

  localparam int unsigned PtrW = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int unsigned CntW = $clog2(QueueDepth + 1);

  shard_entry_t mem_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0] cnt_q;
  logic            do_push, do_pop;

  assign push_ready_o = (cnt_q != CntW'(QueueDepth));
  assign head_valid_o = (cnt_q != '0);
  assign head_o       = mem_q[rd_ptr_q];
  assign do_push      = push_valid_i && push_ready_o;
  assign do_pop       = pop_i && head_valid_o;

  function automatic logic [PtrW-1:0] next_ptr(input logic [PtrW-1:0] p);
    return (p == PtrW'(QueueDepth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= next_ptr(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= next_ptr(rd_ptr_q);
      end
      if (do_push && !do_pop) begin
        cnt_q <= cnt_q + CntW'(1);
      end else if (do_pop && !do_push) begin
        cnt_q <= cnt_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= push_entry_i;
    end
  end

endmodule

>>> hdl/tsrg_back.sv
// Back part: expands the queue head into one shard word per device,
// walking the byte offset with one 64-bit add per word. Depends on tsrg_pkg.
module tsrg_back import tsrg_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         head_valid_i,
  input  shard_entry_t head_i,
  output logic         pop_o,
  input  logic [7:0]   device_kind_i,
  output logic         out_valid_o,
  input  logic         out_ready_i,
  output logic [3:0]   out_ordinal_o,
  output logic [7:0]   out_kind_o,
  output logic [63:0]  out_lo_o,
  output logic [63:0]  out_end_o,
  output logic [1:0]   out_status_o,
  output logic         out_last_o
);

  logic        valid_q, valid_d;
  logic [4:0]  idx_q;
  logic [63:0] run_q;
  logic        adv, is_last;
  logic [63:0] s_cur, s_val, e_val;

  assign adv     = head_valid_i && (!valid_q || out_ready_i);
  assign is_last = (idx_q == head_i.count - 5'd1);
  assign pop_o   = adv && is_last;
  assign valid_d = adv || (valid_q && !out_ready_i);

  always_comb begin
    s_cur = (idx_q == 5'd0) ? head_i.saddr : run_q;
    if (head_i.split) begin
      s_val = s_cur;
      e_val = s_cur + ((idx_q < head_i.rem) ? head_i.chunk_bytes_plus
                                            : head_i.chunk_bytes);
    end else begin
      s_val = head_i.saddr;
      e_val = head_i.eaddr;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= 5'd0;
    end else begin
      valid_q <= valid_d;
      if (adv) begin
        idx_q <= is_last ? 5'd0 : idx_q + 5'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      run_q         <= e_val;
      out_ordinal_o <= idx_q[3:0];
      out_kind_o    <= device_kind_i;
      out_lo_o      <= s_val;
      out_end_o     <= e_val;
      out_status_o  <= head_i.status;
      out_last_o    <= is_last;
    end
  end

  assign out_valid_o = valid_q;

endmodule

>>> hdl/tsrg_checker.sv
// Port-level checks for the tensor shard range generator, bound to the top.
// Depends on tsrg_pkg and tensor_shard_range_generator_unit.
module tsrg_checker import tsrg_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic [OutDataW-1:0] m_axis_tdata,
  input logic [OutUserW-1:0] m_axis_tuser,
  input logic                m_axis_tlast,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready
);

  logic out_acc;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  a_valid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("output word dropped while stalled");

  a_data_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("output data changed while stalled");

  // An error word stands alone: ordinal zero, final, empty range.
  a_error_alone: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[9:8] != StatusOk
      |-> m_axis_tlast && m_axis_tdata[3:0] == 4'd0)
    else $error("error word is not a single final word");

  a_error_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tuser[9:8] != StatusOk |-> m_axis_tdata[131:4] == '0)
    else $error("error word carries a byte range");

  // Back-to-back words of one descriptor count up the device ordinal.
  a_ordinal_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_acc && $past(out_acc) && !$past(m_axis_tlast)
      |-> m_axis_tdata[3:0] == $past(m_axis_tdata[3:0]) + 4'd1)
    else $error("device ordinal skipped within a descriptor");

endmodule

bind tensor_shard_range_generator_unit tsrg_checker u_tsrg_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tuser  (m_axis_tuser),
  .m_axis_tlast  (m_axis_tlast),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready)
);
